// ===== hw/rtl/gre_pkg.sv =====
// ----------------------------------------------------------------------------
// gre_pkg
// Shared constants for the glyph row expander: operation and status codes,
// register indexes, field widths and default sizes.
// ----------------------------------------------------------------------------
package gre_pkg;

  localparam int FONT_STORE_BYTES = 8192;
  localparam int MAX_GLYPH_WIDTH  = 16;
  localparam int MAX_GLYPH_HEIGHT = 32;

  // First printable character held in the font
  localparam logic [7:0] FIRST_CODE = 8'd32;

  // Font address arithmetic width, covers a store of up to 65536 bytes
  localparam int FA_W = 17;

  // Operation codes (input tuser)
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_DRAW  = 2'd2;

  // Result status codes (output tuser)
  localparam logic [1:0] STS_ROW  = 2'd0;
  localparam logic [1:0] STS_CLIP = 2'd1;
  localparam logic [1:0] STS_SKIP = 2'd2;
  localparam logic [1:0] STS_BAD  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_GLYPH_WIDTH   = 3'd0;
  localparam logic [2:0] REG_GLYPH_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_ROW_BYTES     = 3'd2;
  localparam logic [2:0] REG_GLYPH_BYTES   = 3'd3;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd5;

  // Register reset values
  localparam logic [4:0]  RST_GLYPH_WIDTH   = 5'd8;
  localparam logic [5:0]  RST_GLYPH_HEIGHT  = 6'd16;
  localparam logic [1:0]  RST_ROW_BYTES     = 2'd1;
  localparam logic [6:0]  RST_GLYPH_BYTES   = 7'd16;
  localparam logic [10:0] RST_SCREEN_WIDTH  = 11'd240;
  localparam logic [10:0] RST_SCREEN_HEIGHT = 11'd320;

  // Stream widths
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 288;
  localparam int PIX_PER_ROW = 16;

endpackage

// ===== hw/rtl/glyph_row_expander_core.sv =====
// ----------------------------------------------------------------------------
// glyph_row_expander_core
// Bitmap font character generator: expands characters into rows of RGB565
// pixels from a font held in an on-chip glyph store.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis  : one beat per item; tuser selects font write, string begin or
//             character draw. Writes and begins produce no result.
//   m_axis  : one beat per glyph row (status row drawn) or a single beat for
//             a clipped, skipped or bad character; tlast marks the final beat
//             of a character and tuser carries the status.
//   cfg     : register writes, always ready; write only while idle.
// Timing: a draw beat is decoded in the cycle after it is taken. A single
//   result is loaded into the output register from decode once that register
//   is free, and the next beat can be taken in the cycle after the load.
//   Otherwise one glyph row is read from the store per cycle while rows can
//   move on (two read ports give both row bytes at once); each row passes
//   through the store read register into the output register, and the next
//   beat can be taken in the cycle after the last row is loaded.
// Reset: cursor and colours clear, no string is open, registers take their
//   defaults; the glyph store is not cleared and must be loaded before use.
// Stall: a stalled m_axis holds the output register and the row held in the
//   store read register; row reads pause until the output register frees.
// ----------------------------------------------------------------------------
module glyph_row_expander_core #(
  parameter int FontStoreBytes = gre_pkg::FONT_STORE_BYTES,
  parameter int MaxGlyphWidth  = gre_pkg::MAX_GLYPH_WIDTH,
  parameter int MaxGlyphHeight = gre_pkg::MAX_GLYPH_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: font_addr[12:0], font_byte[20:13], char_code[28:21], start_x[38:29],
  //        start_y[48:39], fore_rgb[64:49], back_rgb[80:65], zero pad
  input  logic [gre_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: operation[1:0]
  input  logic [1:0]                      s_axis_tuser,
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: win_x[9:0], win_y[19:10], row_index[24:20], pixels_0_3[88:25],
  //        pixels_4_7[152:89], pixels_8_11[216:153], pixels_12_15[280:217],
  //        zero pad
  output logic [gre_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]                      m_axis_tuser,
  output logic                            m_axis_tlast,
  // Configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [2:0]                      cfg_index_i,
  input  logic [10:0]                     cfg_data_i
);

  localparam int AW   = $clog2(FontStoreBytes);
  localparam int FA_W = gre_pkg::FA_W;
  localparam int NPIX = gre_pkg::PIX_PER_ROW;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DECODE = 3'b010,
    ST_ROWS   = 3'b100
  } state_e;

  // Input fields
  logic [12:0] in_font_addr;
  logic [7:0]  in_font_byte;
  logic [7:0]  in_char_code;
  logic [9:0]  in_start_x;
  logic [9:0]  in_start_y;
  logic [15:0] in_fg;
  logic [15:0] in_bg;

  assign in_font_addr = s_axis_tdata[12:0];
  assign in_font_byte = s_axis_tdata[20:13];
  assign in_char_code = s_axis_tdata[28:21];
  assign in_start_x   = s_axis_tdata[38:29];
  assign in_start_y   = s_axis_tdata[48:39];
  assign in_fg        = s_axis_tdata[64:49];
  assign in_bg        = s_axis_tdata[80:65];

  // Configuration registers
  logic [4:0]  glyph_width_q;
  logic [5:0]  glyph_height_q;
  logic [1:0]  row_bytes_q;
  logic [6:0]  glyph_bytes_q;
  logic [10:0] screen_width_q;
  logic [10:0] screen_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_width_q   <= gre_pkg::RST_GLYPH_WIDTH;
      glyph_height_q  <= gre_pkg::RST_GLYPH_HEIGHT;
      row_bytes_q     <= gre_pkg::RST_ROW_BYTES;
      glyph_bytes_q   <= gre_pkg::RST_GLYPH_BYTES;
      screen_width_q  <= gre_pkg::RST_SCREEN_WIDTH;
      screen_height_q <= gre_pkg::RST_SCREEN_HEIGHT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gre_pkg::REG_GLYPH_WIDTH:   glyph_width_q   <= cfg_data_i[4:0];
        gre_pkg::REG_GLYPH_HEIGHT:  glyph_height_q  <= cfg_data_i[5:0];
        gre_pkg::REG_ROW_BYTES:     row_bytes_q     <= cfg_data_i[1:0];
        gre_pkg::REG_GLYPH_BYTES:   glyph_bytes_q   <= cfg_data_i[6:0];
        gre_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        gre_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective glyph geometry
  logic [4:0] w_eff;
  logic [5:0] h_eff;
  logic [6:0] gb_eff;
  logic       rb2;

  always_comb begin
    if (glyph_width_q == 5'd0) begin
      w_eff = 5'd1;
    end else if (glyph_width_q > 5'(MaxGlyphWidth)) begin
      w_eff = 5'(MaxGlyphWidth);
    end else begin
      w_eff = glyph_width_q;
    end
    if (glyph_height_q == 6'd0) begin
      h_eff = 6'd1;
    end else if (glyph_height_q > 6'(MaxGlyphHeight)) begin
      h_eff = 6'(MaxGlyphHeight);
    end else begin
      h_eff = glyph_height_q;
    end
    gb_eff = (glyph_bytes_q == 7'd0) ? 7'd1 : glyph_bytes_q;
    rb2    = row_bytes_q[1];
  end

  // Control and string state
  state_e      state_q, state_d;
  logic [10:0] cursor_x_q;
  logic [10:0] cursor_y_q;
  logic        ended_q;
  logic [15:0] fore_q;
  logic [15:0] back_q;
  logic [7:0]  code_q;
  logic [9:0]  win_x_q;
  logic [9:0]  win_y_q;
  logic [FA_W-1:0] addr_q;
  logic [4:0]  row_q;
  logic [4:0]  row_last_q;
  logic        rb2_q;

  // Store read stage
  logic        dv_q;
  logic [7:0]  rd_lo_q;
  logic [7:0]  rd_hi_q;
  logic        lo_zero_q;
  logic        hi_zero_q;
  logic [4:0]  dv_row_q;
  logic        dv_last_q;

  // Output register
  logic                 out_valid_q;
  logic [1:0]           out_status_q;
  logic [9:0]           out_win_x_q;
  logic [9:0]           out_win_y_q;
  logic [4:0]           out_row_q;
  logic [NPIX*16-1:0]   out_pix_q;
  logic                 out_last_q;

  logic in_accept;
  logic out_free;
  logic row_load;
  logic read_en;

  assign s_axis_tready = (state_q == ST_IDLE) && !dv_q;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign row_load      = dv_q && out_free;
  assign read_en       = (state_q == ST_ROWS) && (!dv_q || row_load);

  // Decode of a draw item
  logic [11:0]     clip_y_sum;
  logic [11:0]     clip_x_sum;
  logic            clip;
  logic [7:0]      code_off;
  logic [14:0]     base;
  logic            bad;
  logic            single_ok;

  always_comb begin
    clip_y_sum = {1'b0, cursor_y_q} + 12'(h_eff);
    clip_x_sum = {1'b0, cursor_x_q} + 12'(w_eff);
    clip = (clip_y_sum > {1'b0, screen_height_q}) || (clip_x_sum > {1'b0, screen_width_q});
    code_off = code_q - gre_pkg::FIRST_CODE;
    base = 15'(code_off) * 15'(gb_eff);
    bad = (code_q < gre_pkg::FIRST_CODE) || (FA_W'(base) >= FA_W'(FontStoreBytes));
    single_ok = ended_q || clip || bad;
  end

  // Glyph store write
  logic [FA_W-1:0] wr_addr_ext;
  logic            store_we;

  assign wr_addr_ext = FA_W'(in_font_addr);
  assign store_we    = in_accept && (s_axis_tuser == gre_pkg::OP_WRITE) &&
                       (wr_addr_ext < FA_W'(FontStoreBytes));

  // Read addresses of both row bytes
  logic [FA_W-1:0] rd_addr_hi;
  assign rd_addr_hi = addr_q + FA_W'(1);

  logic [7:0] glyph_mem [FontStoreBytes];

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      glyph_mem[wr_addr_ext[AW-1:0]] <= in_font_byte;
    end
    if (read_en) begin
      rd_lo_q <= glyph_mem[addr_q[AW-1:0]];
      rd_hi_q <= glyph_mem[rd_addr_hi[AW-1:0]];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && (s_axis_tuser == gre_pkg::OP_DRAW)) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (single_ok) begin
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_ROWS;
        end
      end
      ST_ROWS: begin
        if (read_en && (row_q == row_last_q)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cursor_x_q <= '0;
      cursor_y_q <= '0;
      ended_q    <= 1'b1;
      fore_q     <= '0;
      back_q     <= '0;
    end else begin
      state_q <= state_d;
      if (in_accept && (s_axis_tuser == gre_pkg::OP_BEGIN)) begin
        cursor_x_q <= {1'b0, in_start_x};
        cursor_y_q <= {1'b0, in_start_y};
        fore_q     <= in_fg;
        back_q     <= in_bg;
        ended_q    <= 1'b0;
      end
      if (state_q == ST_DECODE) begin
        if (!ended_q && clip && out_free) begin
          ended_q <= 1'b1;
        end else if (!single_ok) begin
          cursor_x_q <= cursor_x_q + 11'(w_eff);
        end
      end
    end
  end

  // Per-character working registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      code_q <= in_char_code;
    end
    if ((state_q == ST_DECODE) && !single_ok) begin
      win_x_q    <= cursor_x_q[9:0];
      win_y_q    <= cursor_y_q[9:0];
      addr_q     <= FA_W'(base);
      row_q      <= '0;
      row_last_q <= 5'(h_eff - 6'd1);
      rb2_q      <= rb2;
    end else if (read_en) begin
      addr_q <= addr_q + (rb2_q ? FA_W'(2) : FA_W'(1));
      row_q  <= row_q + 5'd1;
    end
  end

  // Read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= 1'b0;
    end else if (read_en) begin
      dv_q <= 1'b1;
    end else if (row_load) begin
      dv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (read_en) begin
      lo_zero_q <= addr_q >= FA_W'(FontStoreBytes);
      hi_zero_q <= !rb2_q || (rd_addr_hi >= FA_W'(FontStoreBytes));
      dv_row_q  <= row_q;
      dv_last_q <= row_q == row_last_q;
    end
  end

  // Pixel expansion
  logic [15:0]        row_bits;
  logic [NPIX*16-1:0] row_pix;

  always_comb begin
    row_bits[7:0]  = lo_zero_q ? 8'd0 : rd_lo_q;
    row_bits[15:8] = hi_zero_q ? 8'd0 : rd_hi_q;
    for (int x = 0; x < NPIX; x++) begin
      if (5'(x) < w_eff) begin
        row_pix[x*16 +: 16] = row_bits[x] ? fore_q : back_q;
      end else begin
        row_pix[x*16 +: 16] = 16'd0;
      end
    end
  end

  // Output register
  logic single_load;
  assign single_load = (state_q == ST_DECODE) && single_ok && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (row_load || single_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_load) begin
      out_status_q <= gre_pkg::STS_ROW;
      out_win_x_q  <= win_x_q;
      out_win_y_q  <= win_y_q;
      out_row_q    <= dv_row_q;
      out_pix_q    <= row_pix;
      out_last_q   <= dv_last_q;
    end else if (single_load) begin
      // Skipped results carry no window; clip and bad code show the cursor
      if (ended_q) begin
        out_status_q <= gre_pkg::STS_SKIP;
        out_win_x_q  <= '0;
        out_win_y_q  <= '0;
      end else begin
        out_status_q <= clip ? gre_pkg::STS_CLIP : gre_pkg::STS_BAD;
        out_win_x_q  <= cursor_x_q[9:0];
        out_win_y_q  <= cursor_y_q[9:0];
      end
      out_row_q  <= '0;
      out_pix_q  <= '0;
      out_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'd0, out_pix_q, out_row_q, out_win_y_q, out_win_x_q};

endmodule
